// ----- hw/rtl/sdp_pkg.sv -----
// ----------------------------------------------------------------------------
// sdp_pkg
// shared types and constants for the strict decimal parser
// ----------------------------------------------------------------------------
package sdp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned DigitW = 4;
  localparam int unsigned OutTdataW = 40;

  localparam logic [CharW-1:0] ChNul   = 8'd0;
  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChSpace = 8'd32;
  localparam logic [CharW-1:0] ChPlus  = 8'd43;
  localparam logic [CharW-1:0] ChMinus = 8'd45;
  localparam logic [CharW-1:0] ChZero  = 8'd48;
  localparam logic [CharW-1:0] ChNine  = 8'd57;

  localparam logic [ValueW-1:0] PosLimit = 32'd2147483647;
  localparam logic [ValueW-1:0] NegLimit = 32'd2147483648;
  localparam logic [ValueW-1:0] MagSat   = 32'hFFFF_FFFF;

  localparam logic [StatW-1:0] StOk      = 2'd0;
  localparam logic [StatW-1:0] StBadChar = 2'd1;
  localparam logic [StatW-1:0] StRange   = 2'd2;

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_NEG,
    OP_BAD,
    OP_END
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [DigitW-1:0] digit;
  } cmd_t;

endpackage

// ----- hw/rtl/sdp_front.sv -----
// ----------------------------------------------------------------------------
// sdp_front
// classifies incoming characters into parser commands
// ----------------------------------------------------------------------------
module sdp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [sdp_pkg::CharW-1:0]   in_char_i,
  output logic                        in_ready_o,
  output logic                        cmd_valid_o,
  output sdp_pkg::cmd_t               cmd_o,
  input  logic                        cmd_ready_i
);
  import sdp_pkg::*;

  logic phase_q, phase_d;
  logic emit;
  logic is_digit, is_space;
  logic fire;

  assign is_digit   = (in_char_i >= ChZero) && (in_char_i <= ChNine);
  assign is_space   = ((in_char_i >= ChTab) && (in_char_i <= ChCr)) || (in_char_i == ChSpace);
  assign in_ready_o = cmd_ready_i;
  assign fire       = in_valid_i && cmd_ready_i;

  always_comb begin
    phase_d      = phase_q;
    emit         = 1'b1;
    cmd_o.digit  = DigitW'(in_char_i - ChZero);
    cmd_o.op     = is_digit ? OP_DIGIT : OP_BAD;
    if (in_char_i == ChNul) begin
      cmd_o.op = OP_END;
      phase_d  = 1'b0;
    end else if (!phase_q) begin
      if (is_space) begin
        emit = 1'b0;
      end else begin
        phase_d = 1'b1;
        if (in_char_i == ChPlus) begin
          emit = 1'b0;
        end else if (in_char_i == ChMinus) begin
          cmd_o.op = OP_NEG;
        end
      end
    end
  end

  assign cmd_valid_o = in_valid_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ----- hw/rtl/sdp_queue.sv -----
// ----------------------------------------------------------------------------
// sdp_queue
// small command fifo between the front and the back
// ----------------------------------------------------------------------------
module sdp_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  sdp_pkg::cmd_t push_cmd_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output sdp_pkg::cmd_t pop_cmd_o,
  input  logic          pop_ready_i
);
  import sdp_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ----- hw/rtl/sdp_back.sv -----
// ----------------------------------------------------------------------------
// sdp_back
// accumulates the magnitude and forms the result on end of string
// ----------------------------------------------------------------------------
module sdp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  sdp_pkg::cmd_t                cmd_i,
  output logic                         cmd_ready_o,
  output logic                         out_valid_o,
  output logic [sdp_pkg::ValueW-1:0]   out_value_o,
  output logic [sdp_pkg::StatW-1:0]    out_status_o,
  input  logic                         out_ready_i
);
  import sdp_pkg::*;

  logic                neg_q, bad_q;
  logic [ValueW-1:0]   mag_q;
  logic                out_valid_q;
  logic [ValueW-1:0]   value_q, value_d;
  logic [StatW-1:0]    status_q, status_d;
  logic [ValueW+3:0]   mag_next;
  logic                take;

  assign mag_next    = {1'b0, mag_q, 3'b000} + {2'b00, mag_q, 1'b0}
                     + (ValueW+4)'(cmd_i.digit);
  assign cmd_ready_o = (cmd_i.op != OP_END) || !out_valid_q || out_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    value_d  = '0;
    status_d = StOk;
    if (bad_q) begin
      status_d = StBadChar;
    end else if (neg_q) begin
      if (mag_q <= NegLimit) value_d = '0 - mag_q;
      else status_d = StRange;
    end else begin
      if (mag_q <= PosLimit) value_d = mag_q;
      else status_d = StRange;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        unique case (cmd_i.op)
          OP_DIGIT: begin
            mag_q <= (mag_next[ValueW+3:ValueW] != '0) ? MagSat : mag_next[ValueW-1:0];
          end
          OP_NEG: begin
            neg_q <= 1'b1;
          end
          OP_BAD: begin
            bad_q <= 1'b1;
          end
          OP_END: begin
            out_valid_q <= 1'b1;
            neg_q       <= 1'b0;
            bad_q       <= 1'b0;
            mag_q       <= '0;
          end
          default: begin
            bad_q <= bad_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.op == OP_END) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = value_q;
  assign out_status_o = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != StOk) |-> (value_q == '0))
    else $error("nonzero value with error status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i.op == OP_DIGIT && mag_q == MagSat) |=> (mag_q == MagSat))
    else $error("saturated magnitude wrapped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i.op == OP_END) |=> (out_valid_q && mag_q == '0 && !neg_q && !bad_q))
    else $error("end of string did not post result and clear state");

endmodule

// ----- hw/rtl/strict_decimal_to_int32_parser_unit.sv -----
// ----------------------------------------------------------------------------
// strict_decimal_to_int32_parser_unit
// streaming strict decimal string to signed 32-bit integer parser
// ----------------------------------------------------------------------------
// takes one character per cycle while the command queue has room; a zero
// byte ends the string and yields one result (value, status), which passes
// through the command queue register and then the back end's output register.
// throughput is one character per cycle while the queue has room; the back end
// does a multiply-by-ten-and-add for each digit; the queue of QueueDepth commands
// lets the input keep flowing while a result waits on the output
module strict_decimal_to_int32_parser_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] value, [33:32] status, rest zero
);
  import sdp_pkg::*;

  cmd_t              fr_cmd, bk_cmd;
  logic              fr_valid, fr_ready, bk_valid, bk_ready;
  logic [ValueW-1:0] value;
  logic [StatW-1:0]  status;

  sdp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_char_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd),
    .cmd_ready_i (fr_ready)
  );

  sdp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_cmd_i   (fr_cmd),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_cmd_o    (bk_cmd),
    .pop_ready_i  (bk_ready)
  );

  sdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (bk_valid),
    .cmd_i        (bk_cmd),
    .cmd_ready_o  (bk_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_value_o  (value),
    .out_status_o (status),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {(OutTdataW-ValueW-StatW)'(0), status, value};

endmodule
